### design/srfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfc_pkg
// Shared types, constants and microcode program for the sensor record framer.
// ----------------------------------------------------------------------------
package srfc_pkg;

  // Frame geometry
  localparam int unsigned FRAME_BODY_LEN  = 36;
  localparam int unsigned FRAME_TOTAL_LEN = 38;
  localparam int unsigned STEP_W          = 6;
  localparam int unsigned REC_IDX_W       = 5;
  localparam int unsigned REC_FIRST_OFS   = 5;

  // Fixed frame bytes and CRC constants
  localparam logic [7:0]  HDR_BYTE0   = 8'hAA;
  localparam logic [7:0]  HDR_BYTE1   = 8'h55;
  localparam logic [7:0]  TAIL_BYTE0  = 8'h0D;
  localparam logic [7:0]  TAIL_BYTE1  = 8'h0A;
  localparam logic [7:0]  VERSION_RST = 8'h02;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  // One input record
  typedef struct packed {
    logic [31:0] cycle_number;
    logic [31:0] time_ms;
    logic [31:0] temperature_bits;
    logic [31:0] acidity_bits;
    logic [15:0] dissolved_solids;
    logic [31:0] conductivity_bits;
    logic [31:0] oxygen_bits;
    logic [7:0]  oxygen_status;
    logic [7:0]  conductivity_status;
    logic [7:0]  acidity_status;
  } in_item_t;

  // One frame byte
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } out_item_t;

  // Byte source select of a control word
  typedef enum logic [2:0] {
    SRC_LIT     = 3'd0,
    SRC_VERSION = 3'd1,
    SRC_REC     = 3'd2,
    SRC_CRC_LO  = 3'd3,
    SRC_CRC_HI  = 3'd4
  } src_sel_t;

  // Sequencing field of a control word
  typedef enum logic {
    SEQ_NEXT = 1'b0,
    SEQ_END  = 1'b1
  } seq_op_t;

  // Control word
  typedef struct packed {
    src_sel_t               src;
    logic [7:0]             lit;
    logic [REC_IDX_W-1:0]   rec_idx;
    logic                   fold;
    seq_op_t                seq;
  } ucode_t;

  // Microcode program: one control word per frame byte
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t cw;
    cw.src     = SRC_LIT;
    cw.lit     = 8'h00;
    cw.rec_idx = '0;
    cw.fold    = 1'b1;
    cw.seq     = SEQ_NEXT;
    case (step)
      6'd0: begin
        cw.lit = HDR_BYTE0;
      end
      6'd1: begin
        cw.lit = HDR_BYTE1;
      end
      6'd2: begin
        cw.src = SRC_VERSION;
      end
      6'd3: begin
        cw.lit = FRAME_BODY_LEN[7:0];
      end
      6'd4: begin
        cw.lit = FRAME_BODY_LEN[15:8];
      end
      6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14,
      6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23,
      6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32,
      6'd33: begin
        cw.src     = SRC_REC;
        cw.rec_idx = REC_IDX_W'(step - STEP_W'(REC_FIRST_OFS));
      end
      6'd34: begin
        cw.lit = TAIL_BYTE0;
      end
      6'd35: begin
        cw.lit = TAIL_BYTE1;
      end
      6'd36: begin
        cw.src  = SRC_CRC_LO;
        cw.fold = 1'b0;
      end
      6'd37: begin
        cw.src  = SRC_CRC_HI;
        cw.fold = 1'b0;
        cw.seq  = SEQ_END;
      end
      default: begin
        cw.fold = 1'b0;
        cw.seq  = SEQ_END;
      end
    endcase
    return cw;
  endfunction

endpackage

### design/srfc_useq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfc_useq
// Microcode sequencer: step counter, run flag and control store lookup.
// ----------------------------------------------------------------------------
module srfc_useq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               adv,
  output logic               run,
  output srfc_pkg::ucode_t   cw
);

  logic [srfc_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        run_r, run_nxt;

  // Control store read
  assign cw  = srfc_pkg::ucode_rom(step_r);
  assign run = run_r;

  // Step sequencing: restart on a new record, stop on the end word
  always_comb begin
    step_nxt = step_r;
    run_nxt  = run_r;
    if (start) begin
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (adv) begin
      if (cw.seq == srfc_pkg::SEQ_END) begin
        run_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      run_r  <= 1'b0;
    end else begin
      step_r <= step_nxt;
      run_r  <= run_nxt;
    end
  end

endmodule

### design/srfc_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfc_crc16
// CRC-16/MODBUS accumulator, one byte folded per cycle while fold_en is high.
// ----------------------------------------------------------------------------
module srfc_crc16 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clear,
  input  logic        fold_en,
  input  logic [7:0]  byte_in,
  output logic [15:0] crc
);

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] folded;

  // Reflected bitwise fold of one byte
  always_comb begin
    folded = crc_r ^ {8'h00, byte_in};
    for (int k = 0; k < 8; k++) begin
      if (folded[0]) begin
        folded = (folded >> 1) ^ srfc_pkg::CRC_POLY;
      end else begin
        folded = folded >> 1;
      end
    end
  end

  always_comb begin
    crc_nxt = crc_r;
    if (clear) begin
      crc_nxt = srfc_pkg::CRC_INIT;
    end else if (fold_en) begin
      crc_nxt = folded;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= srfc_pkg::CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

### design/sensor_record_framer_crc16_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_record_framer_crc16_unit
// Serializes one sensor record into a 38-byte frame with a CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one record per transaction (valid/ready). The record is latched
//           and the input channel closes until the last frame byte is loaded.
//   out_* : one frame byte per transaction; frame_end marks the last CRC byte.
//   cfg_* : protocol version write, always ready; write only while idle.
// Latency: an accepted record loads the sequencer step and run registers,
//   then the first byte is registered into the output register. Throughput:
//   one frame byte per cycle while the output is not stalled, set by the
//   microcode step counter walking the 38-word control store. The next
//   record is accepted in the cycle the last byte is loaded; frames run back to back.
// Reset: sequencer idle, output empty, version back to 2, CRC to FFFF.
// Stall: while out_ready is low the output register holds its byte and the
//   sequencer waits; no byte is dropped or repeated.
// ----------------------------------------------------------------------------
module sensor_record_framer_crc16_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srfc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output srfc_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);

  srfc_pkg::in_item_t   rec_r;
  srfc_pkg::out_item_t  out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           version_r;
  srfc_pkg::ucode_t     cw;
  logic                 run;
  logic                 adv;
  logic                 start;
  logic [15:0]          crc;
  logic [31:0][7:0]     rec_bytes;
  logic [7:0]           byte_sel;

  // Sequencer steps whenever the output register is free
  assign adv      = run && (!out_valid_r || out_ready);
  assign in_ready = !run || (adv && (cw.seq == srfc_pkg::SEQ_END));
  assign start    = in_valid && in_ready;

  srfc_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .adv   (adv),
    .run   (run),
    .cw    (cw)
  );

  srfc_crc16 u_crc (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (start),
    .fold_en (adv && cw.fold),
    .byte_in (byte_sel),
    .crc     (crc)
  );

  // Record capture
  always_ff @(posedge clk) begin
    if (start) begin
      rec_r <= in_data;
    end
  end

  // Record bytes in frame order, little-endian fields
  assign rec_bytes = {24'h000000, rec_r.acidity_status, rec_r.conductivity_status,
                      rec_r.oxygen_status, rec_r.oxygen_bits,
                      rec_r.conductivity_bits, rec_r.dissolved_solids,
                      rec_r.acidity_bits, rec_r.temperature_bits,
                      rec_r.time_ms, rec_r.cycle_number};

  // Datapath byte select under the control word
  always_comb begin
    case (cw.src)
      srfc_pkg::SRC_LIT:     byte_sel = cw.lit;
      srfc_pkg::SRC_VERSION: byte_sel = version_r;
      srfc_pkg::SRC_REC:     byte_sel = rec_bytes[cw.rec_idx];
      srfc_pkg::SRC_CRC_LO:  byte_sel = crc[7:0];
      srfc_pkg::SRC_CRC_HI:  byte_sel = crc[15:8];
      default:               byte_sel = cw.lit;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (adv) begin
      out_valid_nxt      = 1'b1;
      out_nxt.frame_byte = byte_sel;
      out_nxt.frame_end  = (cw.seq == srfc_pkg::SEQ_END);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Version register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= srfc_pkg::VERSION_RST;
    end else if (cfg_valid && cfg_ready) begin
      version_r <= cfg_data;
    end
  end

endmodule

### design/srfc_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfc_check
// Port-level checks for the sensor record framer, bound to the top level.
// ----------------------------------------------------------------------------
module srfc_check (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input srfc_pkg::out_item_t  out_data,
  input logic                 cfg_ready
);

  // Stalled output byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // Output is empty right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Two frame ends never follow each other
  a_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.frame_end
      |=> !(out_valid && out_data.frame_end))
    else $error("back-to-back frame end");

  // A byte that directly follows a frame end is a header byte
  a_hdr_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.frame_end
      |=> !out_valid || (out_data.frame_byte == srfc_pkg::HDR_BYTE0))
    else $error("frame does not start with header");

  // Version register port never stalls
  a_cfg_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind sensor_record_framer_crc16_unit srfc_check u_srfc_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

### tb/tb_sensor_record_framer_crc16_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_record_framer_crc16_unit
// Self-checking bench for the sensor record framer. Records go in over a
// valid/ready channel. Each accepted record is expanded here into its 38-byte
// frame, with CRC-16/MODBUS over the first 36 bytes and the end flag on the
// last byte. Every frame byte leaving the block is checked against the oldest
// predicted byte. The run starts with directed corner records, then runs
// random phases. Each phase uses its own version byte and its own mix of
// sender gaps and receiver stalls, and one phase includes a long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb_sensor_record_framer_crc16_unit;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 600;
  localparam int REPORT_LIMIT = 10;

  // Float patterns worth hitting often
  localparam logic [31:0] F_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] F_SNAN     = 32'h7F80_0001;
  localparam logic [31:0] F_NEG_NAN  = 32'hFFC0_0000;
  localparam logic [31:0] F_POS_INF  = 32'h7F80_0000;
  localparam logic [31:0] F_NEG_INF  = 32'hFF80_0000;
  localparam logic [31:0] F_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] F_DENORM   = 32'h0000_0001;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  srfc_pkg::in_item_t   in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  srfc_pkg::out_item_t  out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [7:0]           cfg_data = 8'h00;

  srfc_pkg::in_item_t   records_pending[$];
  srfc_pkg::out_item_t  frame_bytes_due[$];
  logic [7:0]           version_shadow = srfc_pkg::VERSION_RST;
  int                   sender_idle_pct = 0;
  int                   receiver_stall_pct = 0;
  logic                 hold_go = 1'b0;
  int                   stall_left = 0;
  int                   error_count = 0;
  int                   bytes_checked = 0;
  int                   cycle_count = 0;

  sensor_record_framer_crc16_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_sensor_record_framer_crc16_unit: done, errors");
      $finish;
    end
  end

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // One byte through the reflected MODBUS CRC
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    int k;
    acc = crc ^ {8'h00, b};
    for (k = 0; k < 8; k++) begin
      if (acc[0]) acc = (acc >> 1) ^ srfc_pkg::CRC_POLY;
      else acc = acc >> 1;
    end
    return acc;
  endfunction

  // Expand one record into the 38 expected frame bytes
  function automatic void predict_frame(input srfc_pkg::in_item_t rec,
                                        input logic [7:0] ver);
    logic [7:0]          fr [srfc_pkg::FRAME_TOTAL_LEN];
    logic [15:0]         crc;
    logic [15:0]         body_len;
    srfc_pkg::out_item_t item;
    int i;
    body_len = 16'(srfc_pkg::FRAME_BODY_LEN);
    fr[0] = srfc_pkg::HDR_BYTE0;
    fr[1] = srfc_pkg::HDR_BYTE1;
    fr[2] = ver;
    fr[3] = body_len[7:0];
    fr[4] = body_len[15:8];
    for (i = 0; i < 4; i++) begin
      fr[5 + i]  = rec.cycle_number[8*i +: 8];
      fr[9 + i]  = rec.time_ms[8*i +: 8];
      fr[13 + i] = rec.temperature_bits[8*i +: 8];
      fr[17 + i] = rec.acidity_bits[8*i +: 8];
      fr[23 + i] = rec.conductivity_bits[8*i +: 8];
      fr[27 + i] = rec.oxygen_bits[8*i +: 8];
    end
    fr[21] = rec.dissolved_solids[7:0];
    fr[22] = rec.dissolved_solids[15:8];
    fr[31] = rec.oxygen_status;
    fr[32] = rec.conductivity_status;
    fr[33] = rec.acidity_status;
    fr[34] = srfc_pkg::TAIL_BYTE0;
    fr[35] = srfc_pkg::TAIL_BYTE1;
    crc = srfc_pkg::CRC_INIT;
    for (i = 0; i < srfc_pkg::FRAME_BODY_LEN; i++) crc = crc16_fold(crc, fr[i]);
    fr[36] = crc[7:0];
    fr[37] = crc[15:8];
    for (i = 0; i < srfc_pkg::FRAME_TOTAL_LEN; i++) begin
      item.frame_byte = fr[i];
      item.frame_end  = (i == srfc_pkg::FRAME_TOTAL_LEN - 1);
      frame_bytes_due.push_back(item);
    end
  endfunction

  function automatic srfc_pkg::in_item_t make_record(
    input logic [31:0] cyc, tm, temp, ph,
    input logic [15:0] tds,
    input logic [31:0] ec, dox,
    input logic [7:0]  st_o, st_c, st_p
  );
    srfc_pkg::in_item_t r;
    r.cycle_number        = cyc;
    r.time_ms             = tm;
    r.temperature_bits    = temp;
    r.acidity_bits        = ph;
    r.dissolved_solids    = tds;
    r.conductivity_bits   = ec;
    r.oxygen_bits         = dox;
    r.oxygen_status       = st_o;
    r.conductivity_status = st_c;
    r.acidity_status      = st_p;
    return r;
  endfunction

  // 32-bit value biased toward extremes and special float patterns
  function automatic logic [31:0] pick32();
    case ($urandom_range(11))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return F_QNAN;
      3: return F_POS_INF;
      4: return F_NEG_INF;
      5: return F_DENORM;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick8();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Input driver: one record per transaction, predicted on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_frame(in_data, version_shadow);
      if (!in_valid || in_ready) begin
        if (records_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= records_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each byte transaction, drives ready with stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_bytes_due.size() == 0) begin
          note_error($sformatf("unexpected frame byte %02h end=%0b",
                               out_data.frame_byte, out_data.frame_end));
        end else begin
          if (out_data.frame_byte !== frame_bytes_due[0].frame_byte)
            note_error($sformatf("frame_byte at offset %0d: expected %02h, got %02h",
                                 bytes_checked % srfc_pkg::FRAME_TOTAL_LEN,
                                 frame_bytes_due[0].frame_byte, out_data.frame_byte));
          if (out_data.frame_end !== frame_bytes_due[0].frame_end)
            note_error($sformatf("frame_end at offset %0d: expected %0b, got %0b",
                                 bytes_checked % srfc_pkg::FRAME_TOTAL_LEN,
                                 frame_bytes_due[0].frame_end, out_data.frame_end));
          void'(frame_bytes_due.pop_front());
          bytes_checked <= bytes_checked + 1;
        end
      end
      // long hold-off, counted here, so the block backs up into its input
      if (hold_go) stall_left <= HOLD_CYCLES;
      else if (stall_left != 0) stall_left <= stall_left - 1;
      out_ready <= !hold_go && (stall_left == 0) &&
                   ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic write_version(input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    version_shadow = value;
  endtask

  task automatic set_traffic(input int idle_pct, input int stall_pct);
    @(negedge clk);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
  endtask

  task automatic queue_random(input int count);
    int n;
    @(negedge clk);
    for (n = 0; n < count; n++)
      records_pending.push_back(make_record(pick32(), pick32(), pick32(), pick32(),
                                            pick16(), pick32(), pick32(),
                                            pick8(), pick8(), pick8()));
  endtask

  // Wait until every record is sent and every frame byte has come back
  task automatic wait_drained();
    @(negedge clk);
    while (records_pending.size() != 0 || in_valid || frame_bytes_due.size() != 0)
      @(negedge clk);
  endtask

  // Stimulus sequence
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed records at the reset version, no idling
    @(negedge clk);
    records_pending.push_back(make_record('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    records_pending.push_back(make_record('1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    records_pending.push_back(make_record(32'd1, 32'd1, F_QNAN, F_SNAN, 16'd1,
                                          F_NEG_NAN, F_QNAN, 8'h01, 8'h01, 8'h01));
    records_pending.push_back(make_record(32'd2, 32'd1000, F_POS_INF, F_NEG_INF, 16'd500,
                                          F_NEG_ZERO, F_DENORM, 8'h00, 8'h80, 8'h7F));
    records_pending.push_back(make_record({4{8'hAA}}, {4{8'hAA}}, {4{8'hAA}}, {4{8'hAA}},
                                          {2{8'hAA}}, {4{8'hAA}}, {4{8'hAA}},
                                          8'hAA, 8'hAA, 8'hAA));
    records_pending.push_back(make_record({4{8'h55}}, {4{8'h55}}, {4{8'h55}}, {4{8'h55}},
                                          {2{8'h55}}, {4{8'h55}}, {4{8'h55}},
                                          8'h55, 8'h55, 8'h55));
    // distinct bytes everywhere catch any byte-order slip
    records_pending.push_back(make_record(32'h0403_0201, 32'h0807_0605, 32'h0C0B_0A09,
                                          32'h100F_0E0D, 16'h1211, 32'h1615_1413,
                                          32'h1A19_1817, 8'h1B, 8'h1C, 8'h1D));
    records_pending.push_back(make_record(32'h8000_0000, 32'h0000_0001, 32'h7F7F_FFFF,
                                          32'h0080_0000, 16'h8000, 32'hFF7F_FFFF,
                                          32'h7FBF_FFFF, 8'h80, 8'h7F, 8'hFE));
    // payload that looks like header and tail bytes
    records_pending.push_back(make_record(32'h0A0D_55AA, 32'h55AA_0A0D, 32'h0024_0002,
                                          32'hAA55_AA55, 16'h0A0D, 32'h0D0A_0D0A,
                                          32'h0000_0024, 8'hAA, 8'h0D, 8'h0A));
    records_pending.push_back(make_record(32'hFFFF_FFFF, 32'h0000_0000, F_NEG_ZERO,
                                          F_DENORM, 16'hFFFF, F_POS_INF, F_NEG_INF,
                                          8'hFF, 8'h00, 8'hFF));
    wait_drained();

    // Version 0, no idling, long receiver hold-off while records keep coming
    write_version(8'h00);
    queue_random(120);
    @(negedge clk);
    hold_go = 1'b1;
    @(negedge clk);
    hold_go = 1'b0;
    wait_drained();

    // Version FF, sender mostly idle
    write_version(8'hFF);
    set_traffic(83, 0);
    queue_random(110);
    wait_drained();

    // Random version, receiver mostly stalled
    write_version(8'($urandom));
    set_traffic(0, 83);
    queue_random(110);
    wait_drained();

    // Random version, light idling on both sides
    write_version(8'($urandom));
    set_traffic(8, 8);
    queue_random(120);
    wait_drained();

    // Tail: nothing more may come out
    set_traffic(0, 0);
    repeat (80) @(posedge clk);
    @(negedge clk);
    if (frame_bytes_due.size() != 0)
      note_error($sformatf("%0d frame bytes never arrived", frame_bytes_due.size()));
    if (error_count == 0) begin
      $display("tb_sensor_record_framer_crc16_unit: done, clean");
    end else begin
      $display("tb_sensor_record_framer_crc16_unit: done, errors");
    end
    $finish;
  end

endmodule

### sensor_record_framer_crc16_unit.f
design/srfc_pkg.sv
design/srfc_useq.sv
design/srfc_crc16.sv
design/sensor_record_framer_crc16_unit.sv
design/srfc_check.sv
tb/tb_sensor_record_framer_crc16_unit.sv
